[sv/crtc_pkg.sv]
// ----------------------------------------------------------------------------
// crtc_pkg: shared types and constants of the clock replacement tag cache
// Field widths, reset values, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package crtc_pkg;

	// Fixed widths of the transaction fields.
	localparam int KEY_W  = 32;
	localparam int SLOT_W = 6;
	localparam int CAP_W  = 7;

	// Defaults of the top-level parameters.
	localparam int DEF_SLOTS    = 64;
	localparam int DEF_KEY_BITS = 32;

	// Capacity register value after reset.
	localparam int CAP_RESET = 64;

	// Code of the kind field that asks for an insert.
	localparam logic KIND_INSERT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RESOLVE,
		ST_SWEEP_RD,
		ST_SWEEP_CHK,
		ST_FINISH
	} state_t;

	// Which result the datapath stages.
	typedef enum logic [1:0] {
		RES_MISS,
		RES_HIT,
		RES_FILL,
		RES_EVICT
	} res_sel_t;

	// Which write the tag memory performs.
	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_TOUCH,
		MEM_FILL,
		MEM_CLEAR,
		MEM_VICTIM
	} mem_op_t;

	typedef struct packed {
		logic     start;
		logic     rd_scan;
		logic     rd_sweep;
		logic     idx_inc;
		logic     hand_init;
		mem_op_t  mem_op;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic filled_zero;
		logic room;
		logic is_insert;
		logic match;
		logic scan_last;
		logic ref_set;
	} status_t;

endpackage

[sv/crtc_ctrl.sv]
// ----------------------------------------------------------------------------
// crtc_ctrl: controller of the clock replacement tag cache
// Sequences the tag scan, the fill or clock sweep, and the result handoff.
// ----------------------------------------------------------------------------
module crtc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_stall,
	input  crtc_pkg::status_t sts,
	output crtc_pkg::cmd_t   cmd,
	output logic             idle,
	output logic             out_valid
);
	import crtc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mem_op  = MEM_NONE;
		cmd.res_sel = RES_MISS;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = sts.filled_zero ? ST_RESOLVE : ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.rd_scan = 1'b1;
				state_d     = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (sts.match) begin
					cmd.mem_op   = MEM_TOUCH;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_HIT;
					state_d      = ST_FINISH;
				end else if (sts.scan_last) begin
					state_d = ST_RESOLVE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_RESOLVE: begin
				if (!sts.is_insert) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_MISS;
					state_d      = ST_FINISH;
				end else if (sts.room) begin
					cmd.mem_op   = MEM_FILL;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_FILL;
					state_d      = ST_FINISH;
				end else begin
					cmd.hand_init = 1'b1;
					state_d       = ST_SWEEP_RD;
				end
			end
			ST_SWEEP_RD: begin
				cmd.rd_sweep = 1'b1;
				state_d      = ST_SWEEP_CHK;
			end
			ST_SWEEP_CHK: begin
				if (sts.ref_set) begin
					cmd.mem_op = MEM_CLEAR;
					state_d    = ST_SWEEP_RD;
				end else begin
					cmd.mem_op   = MEM_VICTIM;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_EVICT;
					state_d      = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[sv/crtc_dpath.sv]
// ----------------------------------------------------------------------------
// crtc_dpath: datapath of the clock replacement tag cache
// Tag memory with a reference bit per slot, fill count, clock hand, capacity
// register, scan index, result staging and the output register.
// ----------------------------------------------------------------------------
module crtc_dpath #(
	parameter int SLOTS    = crtc_pkg::DEF_SLOTS,
	parameter int KEY_BITS = crtc_pkg::DEF_KEY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  crtc_pkg::cmd_t              cmd,
	output crtc_pkg::status_t           sts,
	input  logic                        cfg_we,
	input  logic [crtc_pkg::CAP_W-1:0]  cfg_data,
	input  logic                        kind,
	input  logic [crtc_pkg::KEY_W-1:0]  key,
	output logic                        hit,
	output logic [crtc_pkg::SLOT_W-1:0] slot,
	output logic                        evicted,
	output logic [crtc_pkg::KEY_W-1:0]  evicted_key
);
	import crtc_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CAP_RESET_LIVE = (CAP_RESET < SLOTS) ? CAP_RESET : SLOTS;

	// Each word holds the reference bit above the key tag.
	logic [KEY_BITS:0]   mem [SLOTS];
	logic [KEY_BITS:0]   rdata_q;

	logic [CNT_W-1:0]    cap_q;
	logic [CNT_W-1:0]    fill_count_q;
	logic [IDX_W-1:0]    hand_q;
	logic [IDX_W-1:0]    idx_q;
	logic [KEY_BITS-1:0] key_q;
	logic                kind_q;

	logic                res_hit_q;
	logic [IDX_W-1:0]    res_slot_q;
	logic                res_evicted_q;
	logic [KEY_BITS-1:0] res_evk_q;

	logic                out_hit_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_evicted_q;
	logic [KEY_W-1:0]    out_evk_q;

	logic [CNT_W-1:0]          filled;
	logic [CNT_W-1:0]          idx_plus;
	logic [CNT_W-1:0]          hand_ext;
	logic [CNT_W-1:0]          hand_plus;
	logic [IDX_W-1:0]          hand_next;
	logic [IDX_W-1:0]          raddr;
	logic [IDX_W-1:0]          waddr;
	logic [KEY_BITS:0]         wdata;
	logic [31:0]               cfg_wide;
	logic [CNT_W-1:0]          cap_new;
	logic [KEY_BITS+KEY_W-1:0] key_in_ext;
	logic [KEY_BITS+KEY_W-1:0] evk_ext;
	logic [IDX_W+SLOT_W-1:0]   slot_ext;

	// Slots at or above the live capacity do not count as filled.
	assign filled    = (fill_count_q < cap_q) ? fill_count_q : cap_q;
	assign idx_plus  = CNT_W'(idx_q) + CNT_W'(1);
	assign hand_ext  = CNT_W'(hand_q);
	assign hand_plus = hand_ext + CNT_W'(1);
	assign hand_next = (hand_plus == cap_q) ? '0 : hand_plus[IDX_W-1:0];

	// A capacity of zero acts as one, and any value above the slot count as the slot count.
	assign cfg_wide = 32'(cfg_data);
	always_comb begin
		if (cfg_wide == 32'd0) begin
			cap_new = CNT_W'(1);
		end else if (cfg_wide > 32'(SLOTS)) begin
			cap_new = CNT_W'(SLOTS);
		end else begin
			cap_new = cfg_wide[CNT_W-1:0];
		end
	end

	assign key_in_ext = {{KEY_BITS{1'b0}}, key};

	assign sts.filled_zero = (filled == '0);
	assign sts.room        = (filled < cap_q);
	assign sts.is_insert   = (kind_q == KIND_INSERT);
	assign sts.match       = (rdata_q[KEY_BITS-1:0] == key_q);
	assign sts.scan_last   = (idx_plus == filled);
	assign sts.ref_set     = rdata_q[KEY_BITS];

	assign raddr = cmd.rd_sweep ? hand_q : idx_q;

	always_comb begin
		case (cmd.mem_op)
			MEM_TOUCH: begin
				waddr = idx_q;
				wdata = {1'b1, key_q};
			end
			MEM_FILL: begin
				waddr = filled[IDX_W-1:0];
				wdata = {1'b0, key_q};
			end
			MEM_CLEAR: begin
				waddr = hand_q;
				wdata = {1'b0, rdata_q[KEY_BITS-1:0]};
			end
			MEM_VICTIM: begin
				waddr = hand_q;
				wdata = {1'b0, key_q};
			end
			default: begin
				waddr = idx_q;
				wdata = {1'b0, key_q};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_op != MEM_NONE) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_scan || cmd.rd_sweep) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CNT_W'(CAP_RESET_LIVE);
			fill_count_q <= '0;
			hand_q       <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cap_new;
			end
			if (cmd.mem_op == MEM_FILL) begin
				fill_count_q <= filled + CNT_W'(1);
			end
			if (cmd.hand_init) begin
				if (!(hand_ext < cap_q)) begin
					hand_q <= '0;
				end
			end else if (cmd.mem_op == MEM_CLEAR || cmd.mem_op == MEM_VICTIM) begin
				hand_q <= hand_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q  <= key_in_ext[KEY_BITS-1:0];
			kind_q <= kind;
			idx_q  <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_plus[IDX_W-1:0];
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_HIT: begin
					res_hit_q     <= 1'b1;
					res_slot_q    <= idx_q;
					res_evicted_q <= 1'b0;
					res_evk_q     <= '0;
				end
				RES_FILL: begin
					res_hit_q     <= 1'b0;
					res_slot_q    <= filled[IDX_W-1:0];
					res_evicted_q <= 1'b0;
					res_evk_q     <= '0;
				end
				RES_EVICT: begin
					res_hit_q     <= 1'b0;
					res_slot_q    <= hand_q;
					res_evicted_q <= 1'b1;
					res_evk_q     <= rdata_q[KEY_BITS-1:0];
				end
				default: begin
					res_hit_q     <= 1'b0;
					res_slot_q    <= '0;
					res_evicted_q <= 1'b0;
					res_evk_q     <= '0;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_hit_q     <= res_hit_q;
			out_slot_q    <= slot_ext[SLOT_W-1:0];
			out_evicted_q <= res_evicted_q;
			out_evk_q     <= evk_ext[KEY_W-1:0];
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, res_slot_q};
	assign evk_ext  = {{KEY_W{1'b0}}, res_evk_q};

	assign hit         = out_hit_q;
	assign slot        = out_slot_q;
	assign evicted     = out_evicted_q;
	assign evicted_key = out_evk_q;

endmodule

[sv/clock_replacement_tag_cache_core.sv]
// ----------------------------------------------------------------------------
// clock_replacement_tag_cache_core: fully associative tag store, clock policy
// Looks up and inserts key tags; on a full store the clock hand picks the
// victim with second-chance reference bits and reports the evicted key.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ---------------------------------------
//  input     in_valid / in_stall        kind, key
//  output    out_valid / out_stall      hit, slot, evicted, evicted_key
//  config    cfg_valid / cfg_ready      capacity_in_use
//
// One transaction at a time; the scan and the sweep visit each slot with a
// registered memory read, then a compare. Reset clears fill count and hand and
// sets the capacity to the slot count, at most 64; tags and reference bits are
// read only after a fill writes them. A stalled result waits in the output
// register while the next transaction runs.
//
module clock_replacement_tag_cache_core #(
	parameter int SLOTS    = crtc_pkg::DEF_SLOTS,
	parameter int KEY_BITS = crtc_pkg::DEF_KEY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input transactions.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [crtc_pkg::KEY_W-1:0]  key,
	// Result transactions.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [crtc_pkg::SLOT_W-1:0] slot,
	output logic                        evicted,
	output logic [crtc_pkg::KEY_W-1:0]  evicted_key,
	// Capacity register writes.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [crtc_pkg::CAP_W-1:0]  capacity_in_use
);
	import crtc_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    idle;
	logic    cfg_we;

	// The capacity is only changed between transactions.
	assign cfg_ready = idle;
	assign cfg_we    = cfg_valid && cfg_ready;

	// A new transaction is taken only while the controller sits idle.
	assign in_stall = !idle;

	crtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.idle      (idle),
		.out_valid (out_valid)
	);

	crtc_dpath #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_data    (capacity_in_use),
		.kind        (kind),
		.key         (key),
		.hit         (hit),
		.slot        (slot),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule
